// ----- rtl/cdm_pkg.sv -----
// Shared constants, types and the basis sign rule for the Cayley-Dickson multiplier.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cdm_pkg;

  localparam int unsigned VECTOR_WIDTH    = 64;
  localparam int unsigned DIMENSION       = 4;
  localparam int unsigned COMPONENT_WIDTH = 16;

  // Components that fit entirely inside the packed vector.
  localparam int unsigned FIT_COMPONENTS  = VECTOR_WIDTH / COMPONENT_WIDTH;
  localparam int unsigned LIVE_COMPONENTS =
    (DIMENSION < FIT_COMPONENTS) ? DIMENSION : FIT_COMPONENTS;

  // The algebra is formed at the next power of two; missing components are zero.
  localparam int unsigned LOG_PAD  = $clog2(DIMENSION);
  localparam int unsigned PAD_SIZE = 1 << LOG_PAD;
  localparam int unsigned IDX_W    = (LOG_PAD > 0) ? LOG_PAD : 1;

  typedef logic [VECTOR_WIDTH-1:0]    vector_t;
  typedef logic [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef comp_t [PAD_SIZE-1:0]       comp_vec_t;
  typedef comp_vec_t [PAD_SIZE-1:0]   prod_mat_t;

  // Splits a packed vector into components. Components that are not carried read as zero.
  function automatic comp_vec_t unpack_vector(input vector_t v);
    comp_vec_t c;
    for (int k = 0; k < PAD_SIZE; k++) begin
      if (k < LIVE_COMPONENTS) begin
        c[k] = v[k*COMPONENT_WIDTH +: COMPONENT_WIDTH];
      end else begin
        c[k] = '0;
      end
    end
    return c;
  endfunction

  // Sign of the basis product e_i * e_j, which lands on e_(i^j). Walks the halving
  // levels from the top index bit down. A set top bit on the left selects b, on the
  // right d; conj() flips the sign of every basis element except the first, and the
  // terms d*a and conj(d)*b swap the order of the factors.
  function automatic logic neg_term(input idx_t i, input idx_t j);
    idx_t p;
    idx_t q;
    idx_t t;
    idx_t low_mask;
    logic q_low_nz;
    logic neg;
    neg = 1'b0;
    p   = i;
    q   = j;
    for (int b = int'(LOG_PAD) - 1; b >= 0; b--) begin
      low_mask = IDX_W'((1 << b) - 1);
      q_low_nz = ((q & low_mask) != '0);
      if (p[b] && !q[b]) begin
        neg = neg ^ q_low_nz;
      end else if (!p[b] && q[b]) begin
        t = p;
        p = q;
        q = t;
      end else if (p[b] && q[b]) begin
        neg = neg ^ ~q_low_nz;
        t = p;
        p = q;
        q = t;
      end
    end
    return neg;
  endfunction

endpackage

// ----- rtl/cdm_if.sv -----
// Valid/ready channel interfaces for the operand pair and the product vector.
// Depends on cdm_pkg for the vector type.
interface cdm_in_if;
  logic            valid;
  logic            ready;
  cdm_pkg::vector_t left_vector;
  cdm_pkg::vector_t right_vector;

  modport source (output valid, output left_vector, output right_vector, input ready);
  modport sink   (input valid, input left_vector, input right_vector, output ready);
endinterface

interface cdm_out_if;
  logic            valid;
  logic            ready;
  cdm_pkg::vector_t product_vector;

  modport source (output valid, output product_vector, input ready);
  modport sink   (input valid, input product_vector, output ready);
endinterface

// ----- rtl/cayley_dickson_multiply.sv -----
// Top level of the Cayley-Dickson hypercomplex multiplier.
// Depends on cdm_pkg, the channel interfaces in cdm_if and the cdm_mult_stage block.
//
// Each input beat carries two hypercomplex numbers packed as signed components,
// component 0 in the low bits, and each output beat carries their Cayley-Dickson
// product in the same packing. Every output component is the signed sum of
// component products, wrapped to the component width. The product is worked out as
// a fixed sign table: left component i times right component j adds to or subtracts
// from product component i^j. Operands whose dimension is not a power of two are
// padded with zero components, and only the first components are returned; bits
// above the last packed component are ignored on input and zero on output.
// The block has three register stages (operand, partial product, sum). A beat is
// offered at the output once it has passed through the operand, partial product and
// sum registers in that order, and one beat can be accepted every cycle while the
// output keeps taking beats. Each stage only holds while the stage after it is full
// and stalled, so bubbles are squeezed out. While a finished product waits at the
// output, new operands keep entering until the two stages behind it are full as
// well; only then does the input stall. There is no state beyond the pipeline.
module cayley_dickson_multiply (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdm_in_if.sink            req_i,
  cdm_out_if.source         rsp_o
);

  // Stage valids and the per-stage advance conditions.
  logic s1_valid_q;
  logic s2_valid_q;
  logic s3_valid_q;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign s3_ready  = !s3_valid_q || rsp_o.ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign req_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Operand register.
  cdm_pkg::vector_t left_q;
  cdm_pkg::vector_t right_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_i.valid) begin
      left_q  <= req_i.left_vector;
      right_q <= req_i.right_vector;
    end
  end

  // Partial products, loaded whenever the operand stage moves forward.
  cdm_pkg::prod_mat_t prod;

  cdm_mult_stage u_mult (
    .clk_i   (clk_i),
    .load_i  (s2_ready && s1_valid_q),
    .left_i  (left_q),
    .right_i (right_q),
    .prod_o  (prod)
  );

  // Signed sums per output component. For output k, left component i pairs with
  // right component i^k; the sign table says whether that term is subtracted.
  cdm_pkg::comp_vec_t sum;
  cdm_pkg::vector_t   product_d;
  cdm_pkg::vector_t   product_q;

  always_comb begin
    cdm_pkg::idx_t kk;
    cdm_pkg::idx_t ii;
    cdm_pkg::idx_t jj;
    for (int k = 0; k < cdm_pkg::PAD_SIZE; k++) begin
      kk     = cdm_pkg::IDX_W'(k);
      sum[k] = '0;
      for (int i = 0; i < cdm_pkg::PAD_SIZE; i++) begin
        ii = cdm_pkg::IDX_W'(i);
        jj = ii ^ kk;
        if (cdm_pkg::neg_term(ii, jj)) begin
          sum[k] = sum[k] - prod[ii][jj];
        end else begin
          sum[k] = sum[k] + prod[ii][jj];
        end
      end
    end
  end

  // Only the components that are carried get packed; the rest of the word is zero.
  always_comb begin
    product_d = '0;
    for (int k = 0; k < cdm_pkg::LIVE_COMPONENTS; k++) begin
      product_d[k*cdm_pkg::COMPONENT_WIDTH +: cdm_pkg::COMPONENT_WIDTH] = sum[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      product_q <= product_d;
    end
  end

  assign rsp_o.valid          = s3_valid_q;
  assign rsp_o.product_vector = product_q;

endmodule

// ----- rtl/cdm_mult_stage.sv -----
// Partial product stage: every pairing of left and right components, wrapped to the
// component width and registered. Depends on cdm_pkg.
module cdm_mult_stage (
  input  logic               clk_i,
  input  logic               load_i,
  input  cdm_pkg::vector_t   left_i,
  input  cdm_pkg::vector_t   right_i,
  output cdm_pkg::prod_mat_t prod_o
);

  cdm_pkg::comp_vec_t left_comp;
  cdm_pkg::comp_vec_t right_comp;
  cdm_pkg::prod_mat_t prod_d;
  cdm_pkg::prod_mat_t prod_q;

  assign left_comp  = cdm_pkg::unpack_vector(left_i);
  assign right_comp = cdm_pkg::unpack_vector(right_i);

  // The low bits of the product are the same for signed and unsigned operands.
  always_comb begin
    for (int i = 0; i < cdm_pkg::PAD_SIZE; i++) begin
      for (int j = 0; j < cdm_pkg::PAD_SIZE; j++) begin
        prod_d[i][j] = cdm_pkg::COMPONENT_WIDTH'(left_comp[i] * right_comp[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
